// ===== sv/rgtm_pkg.sv =====
// ----------------------------------------------------------------------------
// rgtm_pkg
// Shared types and constants of the global tone mapper: pixel word
// layout, fixed-point constants and sequencer state codes.
// ----------------------------------------------------------------------------
package rgtm_pkg;

    // Luminance weights in Q0.16 (they sum to 1.0)
    localparam logic [15:0] W_RED   = 16'd17695;
    localparam logic [15:0] W_GREEN = 16'd43909;
    localparam logic [15:0] W_BLUE  = 16'd3932;

    // ceil(2^39 / 255): (n * RECIP_255) >> 39 is n / 255 for any 32-bit n
    localparam logic [31:0] RECIP_255 = 32'h8080_8081;

    // 0.00001 in Q.30
    localparam logic [40:0] EPS_Q30 = 41'd10737;

    // ln(2) in Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Widths
    localparam int X_W   = 41;   // ln argument, Q.30
    localparam int LN_W  = 24;   // ln result, signed Q.16
    localparam int SUM_W = 48;   // log accumulator
    localparam int DIV_W = 64;   // divider operands

    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    // Configuration register indexes
    localparam logic [1:0] CFG_PEAK  = 2'd0;
    localparam logic [1:0] CFG_KEY   = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    // One queued pixel word
    typedef struct packed {
        logic       is_map;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } q_item_t;

    // Back end sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LUM_SUM,
        ST_LUM_MUL,
        ST_LUM_DIV,
        ST_LN_TERM,
        ST_MEAN_GO,
        ST_MEAN_DIV,
        ST_SRCH_GO,
        ST_SRCH_LN,
        ST_K_MUL,
        ST_K_GO,
        ST_K_DIV,
        ST_MAP_MUL,
        ST_MAP_GO,
        ST_MAP_DIV
    } back_state_t;

    // Log unit sequencer
    typedef enum logic [2:0] {
        LN_IDLE,
        LN_NORM,
        LN_SQ,
        LN_MUL,
        LN_FIN
    } ln_state_t;

endpackage

// ===== sv/reinhard_global_tone_map.sv =====
// ----------------------------------------------------------------------------
// reinhard_global_tone_map
// Global tone mapper over two passes of an RGB frame.
//
// Usage: drive a pixel word with start high; it is taken on an edge where
// busy is low. mode 0 words build frame statistics and give no result;
// frame_end on a mode 0 word closes the pass and computes the scale factor.
// mode 1 words are mapped and each yields one result word, shown for one
// cycle with done high; the receiver cannot stall it.
// A two-word queue decouples intake from the back end, which runs one word
// at a time through a shared bit-serial divider and a log unit. A statistics
// word takes one log evaluation, a map word three divisions, and the word
// closing a statistics pass 41 more log evaluations plus two divisions.
// busy rises when the queue holds two words.
// Configuration writes (cfg_we, cfg_index, cfg_data) go in at once. The
// user must see that they are made while the block is idle; the block
// itself does not enforce this. Reset restores the register defaults and
// clears the log sum and the scale factor (zero maps every channel to 0).
// ----------------------------------------------------------------------------
module reinhard_global_tone_map
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        frame_end,
    output logic        done,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        frame_end_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    logic [9:0]        peak_reg;
    logic [15:0]       key_reg;
    logic [20:0]       count_reg;
    logic              q_pop;
    logic              q_valid;
    rgtm_pkg::q_item_t q_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= 10'd100;
            key_reg   <= 16'd23593;
            count_reg <= 21'd640000;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rgtm_pkg::CFG_PEAK)
            begin
                peak_reg <= cfg_data[9:0];
            end
            if (cfg_index == rgtm_pkg::CFG_KEY)
            begin
                key_reg <= cfg_data[15:0];
            end
            if (cfg_index == rgtm_pkg::CFG_COUNT)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    rgtm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .frame_end (frame_end),
        .busy      (busy),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    rgtm_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .peak_luminance (peak_reg),
        .key_value      (key_reg),
        .pixel_count    (count_reg),
        .done           (done),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .frame_end_out  (frame_end_out)
    );

endmodule

// ===== sv/rgtm_div.sv =====
// ----------------------------------------------------------------------------
// rgtm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgtm_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rgtm_pkg::DIV_W-1:0]     dividend,
    input  logic [rgtm_pkg::DIV_W-1:0]     divisor,
    output logic                           busy,
    output logic                           done,
    output logic [rgtm_pkg::DIV_W-1:0]     quotient
);

    logic                          running_reg, running_next;
    logic                          done_reg, done_next;
    logic [6:0]                    cnt_reg, cnt_next;
    logic [rgtm_pkg::DIV_W-1:0]    rem_reg, rem_next;
    logic [rgtm_pkg::DIV_W-1:0]    quo_reg, quo_next;
    logic [rgtm_pkg::DIV_W-1:0]    dsr_reg, dsr_next;
    logic [rgtm_pkg::DIV_W:0]      trial;
    logic [rgtm_pkg::DIV_W:0]      diff;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= 7'd0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    // One shift-subtract step per cycle
    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dsr_next     = dsr_reg;
        trial        = {rem_reg, quo_reg[rgtm_pkg::DIV_W-1]};
        diff         = trial - {1'b0, dsr_reg};
        if (start && !running_reg)
        begin
            running_next = 1'b1;
            cnt_next     = 7'd64;
            rem_next     = '0;
            quo_next     = dividend;
            dsr_next     = divisor;
        end
        else if (running_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[rgtm_pkg::DIV_W-1:0];
                quo_next = {quo_reg[rgtm_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[rgtm_pkg::DIV_W-1:0];
                quo_next = {quo_reg[rgtm_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    assign busy     = running_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/rgtm_ln.sv =====
// ----------------------------------------------------------------------------
// rgtm_ln
// Natural log in signed Q.16 of a Q.30 argument: normalize one bit a
// cycle, 16 squaring steps for the log2 fraction, then scale by ln(2).
// ----------------------------------------------------------------------------
module rgtm_ln
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [rgtm_pkg::X_W-1:0]              x,
    output logic                                  done,
    output logic signed [rgtm_pkg::LN_W-1:0]      result
);

    rgtm_pkg::ln_state_t               state_reg, state_next;
    logic                              done_reg, done_next;
    logic [rgtm_pkg::X_W-1:0]          y_reg, y_next;
    logic [5:0]                        s_reg, s_next;
    logic [30:0]                       m_reg, m_next;
    logic [15:0]                       frac_reg, frac_next;
    logic [3:0]                        it_reg, it_next;
    logic signed [55:0]                prod_reg, prod_next;
    logic signed [rgtm_pkg::LN_W-1:0]  res_reg, res_next;
    logic [61:0]                       sq;
    logic [31:0]                       sq_t;
    logic [6:0]                        expo;
    logic signed [22:0]                val;
    logic signed [55:0]                adj;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgtm_pkg::LN_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        s_reg    <= s_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        it_reg   <= it_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        y_next     = y_reg;
        s_next     = s_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        it_next    = it_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        sq         = 62'(m_reg) * 62'(m_reg);
        sq_t       = sq[61:30];
        expo       = 7'd10 - {1'b0, s_reg};
        val        = {expo, frac_reg};
        adj        = prod_reg + (prod_reg[55] ? 56'sd4294967295 : 56'sd0);
        unique case (state_reg)
            rgtm_pkg::LN_IDLE:
            begin
                if (start)
                begin
                    y_next     = x;
                    s_next     = 6'd0;
                    frac_next  = 16'd0;
                    state_next = rgtm_pkg::LN_NORM;
                end
            end
            rgtm_pkg::LN_NORM:
            begin
                // shift until the top bit is set; mantissa is the upper 31 bits
                if (y_reg[rgtm_pkg::X_W-1])
                begin
                    m_next     = y_reg[rgtm_pkg::X_W-1:rgtm_pkg::X_W-31];
                    it_next    = 4'd0;
                    state_next = rgtm_pkg::LN_SQ;
                end
                else
                begin
                    y_next = {y_reg[rgtm_pkg::X_W-2:0], 1'b0};
                    s_next = s_reg + 6'd1;
                end
            end
            rgtm_pkg::LN_SQ:
            begin
                if (sq_t[31])
                begin
                    m_next    = sq_t[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next    = sq_t[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                it_next = it_reg + 4'd1;
                if (it_reg == 4'd15)
                begin
                    state_next = rgtm_pkg::LN_MUL;
                end
            end
            rgtm_pkg::LN_MUL:
            begin
                prod_next  = 56'(val) * $signed({24'd0, rgtm_pkg::LN2_Q32});
                state_next = rgtm_pkg::LN_FIN;
            end
            rgtm_pkg::LN_FIN:
            begin
                // divide by 2^32 rounding toward zero
                res_next   = adj[55:32];
                done_next  = 1'b1;
                state_next = rgtm_pkg::LN_IDLE;
            end
            default:
            begin
                state_next = rgtm_pkg::LN_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== sv/rgtm_front.sv =====
// ----------------------------------------------------------------------------
// rgtm_front
// Command front end: takes pixel words, tags them as statistics or map
// words and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rgtm_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              mode,
    input  logic [7:0]        red_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        blue_in,
    input  logic              frame_end,
    output logic              busy,
    input  logic              q_pop,
    output logic              q_valid,
    output rgtm_pkg::q_item_t q_item
);

    rgtm_pkg::q_item_t q_mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push;
    logic              pop;
    rgtm_pkg::q_item_t item_in;

    // Classify and pack the incoming word
    always_comb
    begin
        item_in.is_map    = mode;
        item_in.red       = red_in;
        item_in.green     = green_in;
        item_in.blue      = blue_in;
        item_in.frame_end = frame_end;
    end

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;
    assign pop  = q_pop && (count_reg != 2'd0);

    // Pointers and fill
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

endmodule

// ===== sv/rgtm_back.sv =====
// ----------------------------------------------------------------------------
// rgtm_back
// Back end sequencer: luminance and log accumulation, frame statistics
// (mean, log-average search, scale factor) and per-channel mapping.
// ----------------------------------------------------------------------------
module rgtm_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  rgtm_pkg::q_item_t q_item,
    output logic              q_pop,
    input  logic [9:0]        peak_luminance,
    input  logic [15:0]       key_value,
    input  logic [20:0]       pixel_count,
    output logic              done,
    output logic [7:0]        red_out,
    output logic [7:0]        green_out,
    output logic [7:0]        blue_out,
    output logic              frame_end_out
);

    rgtm_pkg::back_state_t              state_reg, state_next;
    rgtm_pkg::q_item_t                  item_reg, item_next;
    logic signed [rgtm_pkg::SUM_W-1:0]  log_sum_reg, log_sum_next;
    logic [31:0]                        scale_reg, scale_next;
    logic [23:0]                        wsum_reg, wsum_next;
    logic [33:0]                        lprod_reg, lprod_next;
    logic signed [rgtm_pkg::SUM_W-1:0]  mean_reg, mean_next;
    logic [rgtm_pkg::X_W-1:0]           x_reg, x_next;
    logic [5:0]                         bit_reg, bit_next;
    logic [48:0]                        d_reg, d_next;
    logic [25:0]                        pk_reg, pk_next;
    logic [39:0]                        v_reg, v_next;
    logic [1:0]                         chan_reg, chan_next;
    logic [7:0]                         ch_r_reg, ch_r_next;
    logic [7:0]                         ch_g_reg, ch_g_next;
    logic                               done_reg, done_next;
    logic [7:0]                         red_reg, red_next;
    logic [7:0]                         green_reg, green_next;
    logic [7:0]                         blue_reg, blue_next;
    logic                               fe_reg, fe_next;

    logic                               div_start;
    logic [rgtm_pkg::DIV_W-1:0]         div_dividend;
    logic [rgtm_pkg::DIV_W-1:0]         div_divisor;
    logic                               div_busy;
    logic                               div_done;
    logic [rgtm_pkg::DIV_W-1:0]         div_q;
    logic                               ln_start;
    logic [rgtm_pkg::X_W-1:0]           ln_x;
    logic                               ln_done;
    logic signed [rgtm_pkg::LN_W-1:0]   ln_res;

    logic signed [rgtm_pkg::SUM_W:0]    sum_wide;
    logic [rgtm_pkg::SUM_W-1:0]         sum_mag;
    logic [rgtm_pkg::X_W-1:0]           cand;
    logic [7:0]                         chan_val;
    logic [7:0]                         chan_res;
    logic [20:0]                        cnt_eff;
    logic [63:0]                        lum_q;

    rgtm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    rgtm_ln u_ln
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ln_start),
        .x      (ln_x),
        .done   (ln_done),
        .result (ln_res)
    );

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rgtm_pkg::ST_IDLE;
            log_sum_reg <= '0;
            scale_reg   <= 32'd0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            log_sum_reg <= log_sum_next;
            scale_reg   <= scale_next;
            done_reg    <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        wsum_reg  <= wsum_next;
        lprod_reg <= lprod_next;
        mean_reg  <= mean_next;
        x_reg     <= x_next;
        bit_reg   <= bit_next;
        d_reg     <= d_next;
        pk_reg    <= pk_next;
        v_reg     <= v_next;
        chan_reg  <= chan_next;
        ch_r_reg  <= ch_r_next;
        ch_g_reg  <= ch_g_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        fe_reg    <= fe_next;
    end

    // Helper terms
    always_comb
    begin
        sum_wide = {log_sum_reg[rgtm_pkg::SUM_W-1], log_sum_reg}
                 + {{(rgtm_pkg::SUM_W + 1 - rgtm_pkg::LN_W){ln_res[rgtm_pkg::LN_W-1]}},
                    ln_res};
        sum_mag  = log_sum_reg[rgtm_pkg::SUM_W-1] ? 48'(-log_sum_reg) : 48'(log_sum_reg);
        cand     = x_reg | (41'd1 << bit_reg);
        cnt_eff  = (pixel_count == 21'd0) ? 21'd1 : pixel_count;
        chan_res = (|div_q[rgtm_pkg::DIV_W-1:8]) ? 8'd255 : div_q[7:0];
        // product / 1020 as (product >> 2) / 255, the latter by reciprocal
        lum_q    = 64'(lprod_reg[33:2]) * 64'(rgtm_pkg::RECIP_255);
        unique case (chan_reg)
            2'd0:    chan_val = item_reg.red;
            2'd1:    chan_val = item_reg.green;
            default: chan_val = item_reg.blue;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        log_sum_next = log_sum_reg;
        scale_next   = scale_reg;
        wsum_next    = wsum_reg;
        lprod_next   = lprod_reg;
        mean_next    = mean_reg;
        x_next       = x_reg;
        bit_next     = bit_reg;
        d_next       = d_reg;
        pk_next      = pk_reg;
        v_next       = v_reg;
        chan_next    = chan_reg;
        ch_r_next    = ch_r_reg;
        ch_g_next    = ch_g_reg;
        done_next    = 1'b0;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        fe_next      = fe_reg;
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = 64'd1;
        ln_start     = 1'b0;
        ln_x         = '0;
        unique case (state_reg)
            rgtm_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    chan_next  = 2'd0;
                    state_next = q_item.is_map ? rgtm_pkg::ST_MAP_MUL
                                               : rgtm_pkg::ST_LUM_SUM;
                end
            end
            // weighted channel sum
            rgtm_pkg::ST_LUM_SUM:
            begin
                wsum_next  = 24'(rgtm_pkg::W_RED) * 24'(item_reg.red)
                           + 24'(rgtm_pkg::W_GREEN) * 24'(item_reg.green)
                           + 24'(rgtm_pkg::W_BLUE) * 24'(item_reg.blue);
                state_next = rgtm_pkg::ST_LUM_MUL;
            end
            // peak * weighted sum
            rgtm_pkg::ST_LUM_MUL:
            begin
                lprod_next = 34'(peak_luminance) * 34'(wsum_reg);
                state_next = rgtm_pkg::ST_LUM_DIV;
            end
            // luminance in Q10.14 is the scaled quotient; start the log
            rgtm_pkg::ST_LUM_DIV:
            begin
                ln_start   = 1'b1;
                ln_x       = {lum_q[63:39], 16'd0} + rgtm_pkg::EPS_Q30;
                state_next = rgtm_pkg::ST_LN_TERM;
            end
            // saturating accumulate
            rgtm_pkg::ST_LN_TERM:
            begin
                if (ln_done)
                begin
                    if (sum_wide[rgtm_pkg::SUM_W] != sum_wide[rgtm_pkg::SUM_W-1])
                    begin
                        log_sum_next = sum_wide[rgtm_pkg::SUM_W] ? rgtm_pkg::SUM_MIN
                                                                 : rgtm_pkg::SUM_MAX;
                    end
                    else
                    begin
                        log_sum_next = sum_wide[rgtm_pkg::SUM_W-1:0];
                    end
                    state_next = item_reg.frame_end ? rgtm_pkg::ST_MEAN_GO
                                                    : rgtm_pkg::ST_IDLE;
                end
            end
            // mean = sum / count, toward zero
            rgtm_pkg::ST_MEAN_GO:
            begin
                div_start    = 1'b1;
                div_dividend = 64'(sum_mag);
                div_divisor  = 64'(cnt_eff);
                state_next   = rgtm_pkg::ST_MEAN_DIV;
            end
            rgtm_pkg::ST_MEAN_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = log_sum_reg[rgtm_pkg::SUM_W-1]
                               ? -div_q[rgtm_pkg::SUM_W-1:0] : div_q[rgtm_pkg::SUM_W-1:0];
                    x_next     = '0;
                    bit_next   = 6'd40;
                    state_next = rgtm_pkg::ST_SRCH_GO;
                end
            end
            // bitwise search for the log-average
            rgtm_pkg::ST_SRCH_GO:
            begin
                ln_start   = 1'b1;
                ln_x       = cand;
                state_next = rgtm_pkg::ST_SRCH_LN;
            end
            rgtm_pkg::ST_SRCH_LN:
            begin
                if (ln_done)
                begin
                    if ($signed({{(rgtm_pkg::SUM_W - rgtm_pkg::LN_W){ln_res[rgtm_pkg::LN_W-1]}},
                                 ln_res}) <= mean_reg)
                    begin
                        x_next = cand;
                    end
                    if (bit_reg == 6'd0)
                    begin
                        state_next = rgtm_pkg::ST_K_MUL;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 6'd1;
                        state_next = rgtm_pkg::ST_SRCH_GO;
                    end
                end
            end
            // K = peak * key * 2^38 / (255 * x)
            rgtm_pkg::ST_K_MUL:
            begin
                d_next     = (x_reg == '0) ? 49'd255
                           : ({x_reg, 8'd0} - {8'd0, x_reg});
                pk_next    = 26'(peak_luminance) * 26'(key_value);
                state_next = rgtm_pkg::ST_K_GO;
            end
            rgtm_pkg::ST_K_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {pk_reg, 38'd0};
                div_divisor  = 64'(d_reg);
                state_next   = rgtm_pkg::ST_K_DIV;
            end
            rgtm_pkg::ST_K_DIV:
            begin
                if (div_done)
                begin
                    scale_next   = (|div_q[63:32]) ? 32'hFFFF_FFFF : div_q[31:0];
                    log_sum_next = '0;
                    state_next   = rgtm_pkg::ST_IDLE;
                end
            end
            // map one channel: 255 v / (2^24 + v)
            rgtm_pkg::ST_MAP_MUL:
            begin
                v_next     = 40'(scale_reg) * 40'(chan_val);
                state_next = rgtm_pkg::ST_MAP_GO;
            end
            rgtm_pkg::ST_MAP_GO:
            begin
                div_start    = 1'b1;
                div_dividend = 64'({v_reg, 8'd0} - {8'd0, v_reg});
                div_divisor  = 64'(v_reg) + 64'h100_0000;
                state_next   = rgtm_pkg::ST_MAP_DIV;
            end
            rgtm_pkg::ST_MAP_DIV:
            begin
                if (div_done)
                begin
                    unique case (chan_reg)
                        2'd0:
                        begin
                            ch_r_next  = chan_res;
                            chan_next  = 2'd1;
                            state_next = rgtm_pkg::ST_MAP_MUL;
                        end
                        2'd1:
                        begin
                            ch_g_next  = chan_res;
                            chan_next  = 2'd2;
                            state_next = rgtm_pkg::ST_MAP_MUL;
                        end
                        default:
                        begin
                            red_next   = ch_r_reg;
                            green_next = ch_g_reg;
                            blue_next  = chan_res;
                            fe_next    = item_reg.frame_end;
                            done_next  = 1'b1;
                            state_next = rgtm_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = rgtm_pkg::ST_IDLE;
            end
        endcase
    end

    assign done          = done_reg;
    assign red_out       = red_reg;
    assign green_out     = green_reg;
    assign blue_out      = blue_reg;
    assign frame_end_out = fe_reg;

    // A mapped word takes three divisions, so strobes never touch
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobes in consecutive cycles");

    // Divider is never left running when the sequencer is idle
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rgtm_pkg::ST_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    // Scale factor changes only at the end of the statistics pass
    a_scale_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (scale_reg != $past(scale_reg)) |-> $past(state_reg == rgtm_pkg::ST_K_DIV))
        else $error("scale factor changed outside its update");

endmodule
